@@ rtl/core/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// Shared widths, constants and types of the sorted range search block.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int unsigned DepthDefault = 1024;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 11;
  localparam int unsigned LenW  = 11;

  localparam logic [PosW-1:0] NotFoundPos = '1;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_PROBE = 6'b000100,
    ST_DONE  = 6'b001000,
    ST_CHK   = 6'b010000,
    ST_EMIT  = 6'b100000
  } srs_state_e;

endpackage

`default_nettype wire

@@ rtl/core/srs_req_if.sv @@
// ----------------------------------------------------------------------------
// srs_req_if
// Request channel: write and query items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srs_req_if
  import srs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [IdxW-1:0]         entry_index;
  logic signed [WordW-1:0] word_value;

  modport source (output valid, output req_type, output entry_index, output word_value,
                  input ready);
  modport sink   (input valid, input req_type, input entry_index, input word_value,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/srs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// srs_rsp_if
// Response channel: query results with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srs_rsp_if
  import srs_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic signed [PosW-1:0] first_position;
  logic signed [PosW-1:0] last_position;

  modport source (output valid, output found, output first_position,
                  output last_position, input ready);
  modport sink   (input valid, input found, input first_position,
                  input last_position, output ready);
endinterface

`default_nettype wire

@@ rtl/core/srs_mem.sv @@
// ----------------------------------------------------------------------------
// srs_mem
// Sorted word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_mem
  import srs_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire  [AW-1:0]           waddr_i,
  input  wire  [WordW-1:0]        wdata_i,
  input  wire                     re_i,
  input  wire  [AW-1:0]           raddr_i,
  output logic [WordW-1:0]        rdata_o
);

  logic [WordW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srs_ctrl.sv @@
// ----------------------------------------------------------------------------
// srs_ctrl
// Search sequencer: lower-bound probe, hit check, upper-bound probe, result.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ctrl
  import srs_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [LenW-1:0]   len_i,
  srs_req_if.sink           req,
  srs_rsp_if.source         rsp,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [WordW-1:0]  mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  wire  [WordW-1:0]  mem_rdata_i
);

  localparam int unsigned PW = $clog2(DEPTH + 1);

  srs_state_e state_q, state_d;

  logic [PW-1:0]           lo_q, lo_d, hp_q, hp_d, ans_q, ans_d, mid_q, mid_d;
  logic [PW-1:0]           n_q, n_d, lb_q, lb_d;
  logic                    strict_q, strict_d;
  logic signed [WordW-1:0] key_q, key_d;
  logic                    res_found_q, res_found_d;
  logic [PosW-1:0]         res_first_q, res_first_d, res_last_q, res_last_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q;
  logic [PosW-1:0]         out_first_q, out_last_q;
  logic                    out_load;

  logic                    accept;
  logic [31:0]             idx_ext, len_ext, mid_ext, ans_ext, lb_ext, last_ext;
  logic signed [WordW-1:0] rd_s;
  logic                    hit;
  logic [PW-1:0]           nlo, nhp, nans, nmid;
  logic [PW:0]             msum;
  logic [PW-1:0]           mid_p1;

  assign accept   = req.valid && req.ready;
  assign idx_ext  = 32'(req.entry_index);
  assign len_ext  = 32'(len_i);
  assign rd_s     = $signed(mem_rdata_i);
  assign mid_p1   = mid_q + PW'(1);

  assign hit  = strict_q ? (rd_s > key_q) : (rd_s >= key_q);
  assign nlo  = (state_q == ST_PROBE && !hit) ? mid_p1 : lo_q;
  assign nhp  = (state_q == ST_PROBE && hit) ? mid_q : hp_q;
  assign nans = (state_q == ST_PROBE && hit) ? mid_q : ans_q;
  assign msum = {1'b0, nlo} + {1'b0, nhp} - (PW + 1)'(1);
  assign nmid = msum[PW:1];

  assign mid_ext  = 32'(nmid);
  assign ans_ext  = 32'(ans_q);
  assign lb_ext   = 32'(lb_q);
  assign last_ext = ans_ext - 32'd1;

  assign req.ready = (state_q == ST_IDLE);

  assign mem_we_o    = accept && (req.req_type == ReqWrite) && (idx_ext < 32'(DEPTH));
  assign mem_waddr_o = idx_ext[AW-1:0];
  assign mem_wdata_o = req.word_value;

  always_comb begin
    state_d     = state_q;
    lo_d        = nlo;
    hp_d        = nhp;
    ans_d       = nans;
    mid_d       = mid_q;
    n_d         = n_q;
    lb_d        = lb_q;
    strict_d    = strict_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_first_d = res_first_q;
    res_last_d  = res_last_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = mid_ext[AW-1:0];
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && req.req_type == ReqQuery) begin
          key_d    = req.word_value;
          n_d      = len_ext[PW-1:0];
          lo_d     = '0;
          hp_d     = len_ext[PW-1:0];
          ans_d    = len_ext[PW-1:0];
          strict_d = 1'b0;
          state_d  = ST_START;
        end
      end
      ST_START, ST_PROBE: begin
        if (nlo < nhp) begin
          mem_re_o = 1'b1;
          mid_d    = nmid;
          state_d  = ST_PROBE;
        end else begin
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (strict_q) begin
          res_found_d = 1'b1;
          res_first_d = lb_ext[PosW-1:0];
          res_last_d  = last_ext[PosW-1:0];
          state_d     = ST_EMIT;
        end else if (ans_q == n_q) begin
          res_found_d = 1'b0;
          res_first_d = NotFoundPos;
          res_last_d  = NotFoundPos;
          state_d     = ST_EMIT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ans_ext[AW-1:0];
          state_d     = ST_CHK;
        end
      end
      ST_CHK: begin
        if (rd_s == key_q) begin
          lb_d     = ans_q;
          lo_d     = '0;
          hp_d     = n_q;
          ans_d    = n_q;
          strict_d = 1'b1;
          state_d  = ST_START;
        end else begin
          res_found_d = 1'b0;
          res_first_d = NotFoundPos;
          res_last_d  = NotFoundPos;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hp_q        <= hp_d;
    ans_q       <= ans_d;
    mid_q       <= mid_d;
    n_q         <= n_d;
    lb_q        <= lb_d;
    strict_q    <= strict_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_first_q <= res_first_d;
    res_last_q  <= res_last_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_first_q <= res_first_q;
      out_last_q  <= res_last_q;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.found          = out_found_q;
  assign rsp.first_position = out_first_q;
  assign rsp.last_position  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/sorted_range_search_core.sv @@
// ----------------------------------------------------------------------------
// sorted_range_search_core
// First and last position of a key in an ascending store of signed words.
//
// req_i carries write items (req_type 0: entry_index, word_value stored) and
// query items (req_type 1: word_value is the key). A write gives no result.
// A query gives one item on rsp_o: found, and the first and last index of
// the key, both -1 when the key is absent.
// cfg_we_i/cfg_wdata_i set the number of entries searched, saturated at
// DEPTH or 2047, whichever is smaller; write it only while the block is idle.
// A query runs two binary searches on the store memory, one probe a cycle
// since the compare feeds the next read address directly.
// The finished result sits in an output register, so the next item is taken
// while rsp_o is stalled; a second result waits until that register frees.
// Reset clears the length to zero and the control state; store contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_search_core
  import srs_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [LenW-1:0]   cfg_wdata_i,
  srs_req_if.sink           req_i,
  srs_rsp_if.source         rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LenW-1:0] LenCap = (DEPTH > 2047) ? LenW'(2047) : LenW'(DEPTH);

  logic [LenW-1:0]  len_q, len_d;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;

  assign len_d = (cfg_wdata_i > LenCap) ? LenCap : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= len_d;
    end
  end

  srs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_q),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  srs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
